@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

    localparam int IN_DATA_BITS  = ((PAYLOAD_BITS + PRIORITY_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 2 * PAYLOAD_BITS + PRIORITY_BITS + 1 + 2 + 1 + COUNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY_DEQ = 2'd1;
    localparam logic [1:0] ST_FULL_ENQ  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } spq_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } spq_cmd_t;

    typedef struct packed {
        logic out_busy;
    } spq_stat_t;

endpackage

@@ design/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of 16 cells.
// ----------------------------------------------------------------------------
// Each input word enqueues (tuser 0) or dequeues the front entry (tuser 1) and
// gives exactly one output word. An item is first registered; then every cell
// compares and shifts in parallel and the result is loaded into the output
// register. The next word is taken while a result waits, but a commit stalls
// until the output register is free. Equal priorities are served oldest first.
// No initialization pass after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [31:0] payload, [39:32] priority_req
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // [0] kind
    input  logic [0:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [31:0] out_payload, [32] out_valid, [34:33] status, [66:35] head_payload,
    // [74:67] head_priority, [75] head_valid, [80:76] entry_count, rest zero
    output logic [OUT_DATA_BITS-1:0] m_tdata
);

    spq_cmd_t                cmd;
    spq_stat_t               stat;
    logic [OUT_RAW_BITS-1:0] out_word;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser[0]),
        .in_payload  (s_tdata[PAYLOAD_BITS-1:0]),
        .in_priority (s_tdata[PAYLOAD_BITS+PRIORITY_BITS-1:PAYLOAD_BITS]),
        .out_vld     (m_tvalid),
        .out_rdy     (m_tready),
        .out_word    (out_word)
    );

    assign m_tdata = OUT_DATA_BITS'(out_word);

endmodule

@@ design/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes one word, then commits it once the output register is free.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    spq_state_t state_reg;
    spq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_EXEC: begin
                cmd.commit = !stat.out_busy;
            end
            default: ;
        endcase
    end

endmodule

@@ design/spq_dpath.sv @@
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted cell chain with input and output registers.
// ----------------------------------------------------------------------------
module spq_dpath
    import spq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  spq_cmd_t                 cmd,
    output spq_stat_t                stat,
    input  logic                     in_kind,
    input  logic [PAYLOAD_BITS-1:0]  in_payload,
    input  logic [PRIORITY_BITS-1:0] in_priority,
    output logic                     out_vld,
    input  logic                     out_rdy,
    output logic [OUT_RAW_BITS-1:0]  out_word
);

    logic                     kind_reg;
    logic [PAYLOAD_BITS-1:0]  pay_reg;
    logic [PRIORITY_BITS-1:0] pri_reg;

    logic [PAYLOAD_BITS-1:0]  slot_pay_reg  [CAPACITY];
    logic [PRIORITY_BITS-1:0] slot_pri_reg  [CAPACITY];
    logic [PAYLOAD_BITS-1:0]  slot_pay_next [CAPACITY];
    logic [PRIORITY_BITS-1:0] slot_pri_next [CAPACITY];
    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;

    logic [CAPACITY-1:0]      keep;
    logic                     is_full;
    logic                     is_empty;
    logic [PAYLOAD_BITS-1:0]  removed;
    logic                     removed_vld;
    logic [1:0]               status;
    logic                     head_vld;

    logic                     out_vld_reg;
    logic [OUT_RAW_BITS-1:0]  out_word_reg;

    assign is_full  = (count_reg == COUNT_BITS'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // keep: slot stays in place on insert (older or higher priority)
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            keep[i] = (COUNT_BITS'(i) < count_reg) && (slot_pri_reg[i] >= pri_reg);
        end
    end

    always_comb begin
        count_next  = count_reg;
        removed     = '0;
        removed_vld = 1'b0;
        status      = ST_OK;
        for (int i = 0; i < CAPACITY; i++) begin
            slot_pay_next[i] = slot_pay_reg[i];
            slot_pri_next[i] = slot_pri_reg[i];
        end
        if (kind_reg == KIND_ENQ) begin
            if (is_full) begin
                status = ST_FULL_ENQ;
            end else begin
                count_next = count_reg + COUNT_BITS'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!keep[i]) begin
                        if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                            slot_pay_next[i] = pay_reg;
                            slot_pri_next[i] = pri_reg;
                        end else begin
                            slot_pay_next[i] = slot_pay_reg[(i == 0) ? 0 : i - 1];
                            slot_pri_next[i] = slot_pri_reg[(i == 0) ? 0 : i - 1];
                        end
                    end
                end
            end
        end else begin
            if (is_empty) begin
                status = ST_EMPTY_DEQ;
            end else begin
                count_next  = count_reg - COUNT_BITS'(1);
                removed     = slot_pay_reg[0];
                removed_vld = 1'b1;
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    slot_pay_next[i] = slot_pay_reg[i + 1];
                    slot_pri_next[i] = slot_pri_reg[i + 1];
                end
            end
        end
    end

    assign head_vld = (count_next != '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            pay_reg  <= in_payload;
            pri_reg  <= in_priority;
        end
        if (cmd.commit) begin
            for (int i = 0; i < CAPACITY; i++) begin
                slot_pay_reg[i] <= slot_pay_next[i];
                slot_pri_reg[i] <= slot_pri_next[i];
            end
            // fields from the highest bit down
            out_word_reg <= {count_next,
                             head_vld,
                             head_vld ? slot_pri_next[0] : {PRIORITY_BITS{1'b0}},
                             head_vld ? slot_pay_next[0] : {PAYLOAD_BITS{1'b0}},
                             status,
                             removed_vld,
                             removed};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                count_reg   <= count_next;
                out_vld_reg <= 1'b1;
            end else if (out_rdy) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign stat.out_busy = out_vld_reg && !out_rdy;
    assign out_vld       = out_vld_reg;
    assign out_word      = out_word_reg;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking stream testbench for the sorted priority queue.
// ----------------------------------------------------------------------------
// A queue of enqueue/dequeue words feeds a clocked driver. A clocked monitor
// checks every result word against a shadow copy of the sorted queue.
// The directed opening covers empty dequeue, extreme payloads and priorities,
// equal-priority ordering, a full queue and a dropped enqueue. The random
// phases that follow push the fill level between empty and full. Both sides
// insert random gaps. One long receiver hold backs the block up into its
// input.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int P = PAYLOAD_BITS;
    localparam int R = PRIORITY_BITS;
    localparam int O_VALID  = P;
    localparam int O_STATUS = O_VALID + 1;
    localparam int O_HPAY   = O_STATUS + 2;
    localparam int O_HPRI   = O_HPAY + P;
    localparam int O_HVALID = O_HPRI + R;
    localparam int O_COUNT  = O_HVALID + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_OPS   = 175;

    typedef struct packed {
        logic         kind;
        logic [P-1:0] payload;
        logic [R-1:0] prio;
    } pq_op_t;

    typedef struct packed {
        logic [P-1:0]          out_payload;
        logic                  out_valid;
        logic [1:0]            status;
        logic [P-1:0]          head_payload;
        logic [R-1:0]          head_prio;
        logic                  head_valid;
        logic [COUNT_BITS-1:0] entry_count;
    } pq_result_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [0:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    pq_op_t     pending_ops[$];
    pq_result_t expected_results[$];

    logic [P-1:0] shadow_pay[CAPACITY];
    logic [R-1:0] shadow_pri[CAPACITY];
    int           shadow_count = 0;

    int unsigned ops_queued   = 0;
    int unsigned ops_accepted = 0;
    int unsigned fault_count  = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned cycle_count  = 0;
    bit          no_idle      = 1'b0;

    sorted_priority_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // shadow queue: insert behind all entries of greater or equal priority
    function automatic pq_result_t pq_apply(logic kind, logic [P-1:0] pay, logic [R-1:0] pri);
        pq_result_t r;
        int         pos;
        r = '0;
        r.status = ST_OK;
        if (kind == KIND_ENQ) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL_ENQ;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_pri[pos] >= pri) pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_pay[k] = shadow_pay[k-1];
                    shadow_pri[k] = shadow_pri[k-1];
                end
                shadow_pay[pos] = pay;
                shadow_pri[pos] = pri;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY_DEQ;
            end else begin
                r.out_payload = shadow_pay[0];
                r.out_valid   = 1'b1;
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_pay[k-1] = shadow_pay[k];
                    shadow_pri[k-1] = shadow_pri[k];
                end
                shadow_count--;
            end
        end
        if (shadow_count > 0) begin
            r.head_payload = shadow_pay[0];
            r.head_prio    = shadow_pri[0];
            r.head_valid   = 1'b1;
        end
        r.entry_count = COUNT_BITS'(shadow_count);
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fault_count++;
        end
    endtask

    task automatic push_op(logic kind, logic [P-1:0] pay, logic [R-1:0] pri);
        pq_op_t op;
        op.kind    = kind;
        op.payload = pay;
        op.prio    = pri;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    task automatic queue_phase(int n, int enq_pct, int lo, int hi);
        for (int i = 0; i < n; i++) begin
            push_op(($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ,
                    P'($urandom), R'($urandom_range(lo, hi)));
        end
    endtask

    task automatic wait_accepted();
        while (ops_accepted != ops_queued) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : op_driver
        pq_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(pq_apply(s_tuser[0], s_tdata[0 +: P], s_tdata[P +: R]));
                ops_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops.pop_front();
                    s_tdata  <= IN_DATA_BITS'({op.prio, op.payload});
                    s_tuser  <= op.kind;
                    s_tvalid <= 1'b1;
                    gap_left <= draw_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        pq_result_t  want;
        int unsigned st;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            st = stall_left;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected");
                    fault_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("out_payload", want.out_payload, m_tdata[0 +: P]);
                    compare_field("out_valid", want.out_valid, m_tdata[O_VALID]);
                    compare_field("status", want.status, m_tdata[O_STATUS +: 2]);
                    compare_field("head_payload", want.head_payload, m_tdata[O_HPAY +: P]);
                    compare_field("head_priority", want.head_prio, m_tdata[O_HPRI +: R]);
                    compare_field("head_valid", want.head_valid, m_tdata[O_HVALID]);
                    compare_field("entry_count", want.entry_count,
                                  m_tdata[O_COUNT +: COUNT_BITS]);
                end
                st = draw_gap();
            end else if (st != 0) begin
                st = st - 1;
            end
            if (hold_seen != hold_req) begin
                st = LONG_HOLD;
                hold_seen++;
            end
            m_tready   <= (st == 0);
            stall_left <= st;
        end
    end

    initial begin : run_limit
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sorted_priority_queue regression: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty dequeue, extremes, ties, fill, drop on full, drain part
        push_op(KIND_DEQ, 32'h1234_5678, 8'd9);
        push_op(KIND_ENQ, 32'h0000_0000, 8'd0);
        push_op(KIND_ENQ, 32'hFFFF_FFFF, 8'd255);
        push_op(KIND_ENQ, 32'h0000_00A1, 8'd100);
        push_op(KIND_ENQ, 32'h0000_00A2, 8'd100);
        push_op(KIND_ENQ, 32'h0000_00A3, 8'd100);
        push_op(KIND_ENQ, 32'hFFFF_FFFE, 8'd255);
        push_op(KIND_ENQ, 32'h0000_0005, 8'd1);
        push_op(KIND_ENQ, 32'h0000_0006, 8'd254);
        push_op(KIND_ENQ, 32'h0000_0007, 8'd0);
        push_op(KIND_ENQ, 32'h0000_0008, 8'd128);
        push_op(KIND_ENQ, 32'h0000_0009, 8'd100);
        push_op(KIND_ENQ, 32'hAAAA_AAAA, 8'd127);
        push_op(KIND_ENQ, 32'h5555_5555, 8'd129);
        push_op(KIND_ENQ, 32'h0000_000C, 8'd1);
        push_op(KIND_ENQ, 32'h0000_000D, 8'd200);
        push_op(KIND_ENQ, 32'h0000_000E, 8'd255);
        push_op(KIND_ENQ, 32'h0000_000F, 8'd255);
        for (int i = 0; i < 7; i++) push_op(KIND_DEQ, 32'hFFFF_FFFF, 8'd255);
        wait_accepted();

        queue_phase(PHASE_OPS, 50, 0, 255);
        wait_accepted();

        // back-to-back words against a long receiver hold
        no_idle = 1'b1;
        queue_phase(PHASE_OPS, 80, 0, 3);
        hold_req++;
        wait_accepted();

        no_idle = 1'b0;
        queue_phase(PHASE_OPS, 20, 0, 255);
        wait_accepted();
        queue_phase(PHASE_OPS, 70, 250, 255);
        wait_accepted();

        no_idle = 1'b1;
        queue_phase(PHASE_OPS, 50, 0, 1);
        wait_accepted();

        no_idle = 1'b0;
        queue_phase(PHASE_OPS, 60, 0, 255);
        wait_accepted();
        queue_phase(PHASE_OPS, 35, 0, 7);
        wait_accepted();

        no_idle = 1'b1;
        queue_phase(PHASE_OPS, 55, 0, 255);
        wait_accepted();

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fault_count == 0 && expected_results.size() == 0) begin
            $display("sorted_priority_queue regression: pass");
        end else begin
            $display("sorted_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
